[rtl/core/trc_pkg.sv]
// Shared types and constants for the terminated command receiver.
// Used by trc_ctrl, trc_dp and terminated_command_receiver; depends on nothing.
`default_nettype none

package trc_pkg;

  // Input command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Special characters
  localparam logic [7:0] CHAR_TERM = 8'h23;  // '#'
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHAR,
    ST_STATUS
  } ctrl_state_t;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_BYTE,
    OP_CLEAR,
    OP_PEEK,
    OP_READ_START,
    OP_FETCH,
    OP_CHAR,
    OP_READ_STATUS
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic has_chars;   // command ready, no overflow, nonzero length
    logic rdata_zero;  // fetched character is a zero byte
    logic idx_last;    // read index is at the last stored character
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/terminated_command_receiver.sv]
// Top level of the terminated command receiver: controller plus datapath.
// Depends on trc_pkg, trc_ctrl and trc_dp.
//
// Builds '#'-terminated commands from received bytes. Command 0 transfers a
// received byte: CR and LF are skipped, a byte arriving while a finished
// command is pending sets the sticky trailing flag, '#' finishes the command,
// any other byte is stored until MAX_PAYLOAD bytes are held, after which the
// sticky overflow flag is set. Every received byte bumps a wrapping 16-bit
// activity count. Command 1 reads: the stored characters come out one per
// result (stopping at the first zero byte, and suppressed entirely on
// overflow), followed by a status result with last set; then the receiver
// is cleared. Command 2 clears the receiver; command 3 only reports status.
// The activity count survives every clear. Byte, clear and status commands
// are accepted back to back while the output register drains. A read runs
// a start step, then a fetch and a character step per character, then a
// status step, because each character goes through the payload memory's
// registered read port before it reaches the output register. No clearing
// pass is needed after reset; the block is ready as soon as reset is released.
`default_nettype none

module terminated_command_receiver
  import trc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_has_char,
  output logic [7:0]       out_char_out,
  output logic             out_overflow_flag,
  output logic             out_trailing_flag,
  output logic             out_empty_flag,
  output logic             out_available,
  output logic [15:0]      out_activity_count,
  output logic             out_last
);

  dp_op_t     op;
  dp_status_t status;

  // Sequence reads and gate input transfers
  trc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .status     (status),
    .op         (op)
  );

  // Hold receiver state, payload memory and the output register
  trc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_rx_byte         (in_rx_byte),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_has_char       (out_has_char),
    .out_char_out       (out_char_out),
    .out_overflow_flag  (out_overflow_flag),
    .out_trailing_flag  (out_trailing_flag),
    .out_empty_flag     (out_empty_flag),
    .out_available      (out_available),
    .out_activity_count (out_activity_count),
    .out_last           (out_last)
  );

  // A non-read transfer yields its single, final result in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command != CMD_READ)) |=> (out_valid && out_last))
    else $error("non-read transfer did not produce a final result");

  // Character results are never final, never zero and never seen on overflow
  a_char_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_char) |->
      (!out_last && (out_char_out != 8'd0) && !out_overflow_flag && !out_empty_flag))
    else $error("malformed character result");

  // Empty status only closes a read and never coexists with overflow
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_flag) |-> (out_last && !out_overflow_flag && !out_has_char))
    else $error("malformed empty status");

endmodule

`default_nettype wire

[rtl/core/trc_ctrl.sv]
// Controller state machine for the terminated command receiver.
// Depends on trc_pkg; drives trc_dp through dp_op_t and reads dp_status_t.
`default_nettype none

module trc_ctrl
  import trc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          unique case (in_command)
            CMD_BYTE:  op = OP_BYTE;
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ: begin
              op        = OP_READ_START;
              state_nxt = status.has_chars ? ST_FETCH : ST_STATUS;
            end
            default:   op = OP_PEEK;
          endcase
        end
      end
      ST_FETCH: begin
        op        = OP_FETCH;
        state_nxt = ST_CHAR;
      end
      ST_CHAR: begin
        // stop at a zero byte, else emit and advance
        if (status.rdata_zero) begin
          state_nxt = ST_STATUS;
        end else if (status.out_free) begin
          op        = OP_CHAR;
          state_nxt = status.idx_last ? ST_STATUS : ST_FETCH;
        end
      end
      ST_STATUS: begin
        if (status.out_free) begin
          op        = OP_READ_STATUS;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/trc_dp.sv]
// Datapath for the terminated command receiver: receiver state, payload
// memory and output register. Depends on trc_pkg; controlled by trc_ctrl.
`default_nettype none

module trc_dp
  import trc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_op_t      op,
  input  wire logic [7:0]  in_rx_byte,
  output dp_status_t       status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_has_char,
  output logic [7:0]       out_char_out,
  output logic             out_overflow_flag,
  output logic             out_trailing_flag,
  output logic             out_empty_flag,
  output logic             out_available,
  output logic [15:0]      out_activity_count,
  output logic             out_last
);

  localparam int PW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rdata_r;

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic          rdy_r, rdy_nxt;
  logic          ovf_r, ovf_nxt;
  logic          trl_r, trl_nxt;
  logic [15:0]   act_r, act_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          any_r, any_nxt;
  logic          store_en;

  logic          out_valid_r, out_valid_nxt;
  logic          o_has_r, o_has_nxt;
  logic [7:0]    o_char_r, o_char_nxt;
  logic          o_ovf_r, o_ovf_nxt;
  logic          o_trl_r, o_trl_nxt;
  logic          o_emp_r, o_emp_nxt;
  logic          o_avl_r, o_avl_nxt;
  logic [15:0]   o_act_r, o_act_nxt;
  logic          o_last_r, o_last_nxt;
  logic          load;

  logic          is_crlf;
  logic          out_free;

  assign is_crlf  = (in_rx_byte == CHAR_CR) || (in_rx_byte == CHAR_LF);
  assign out_free = !out_valid_r || out_ready;

  assign status.out_free   = out_free;
  assign status.has_chars  = rdy_r && !ovf_r && (len_r != '0);
  assign status.rdata_zero = (rdata_r == 8'd0);
  assign status.idx_last   = ((PW'(idx_r) + PW'(1)) == len_r);

  always_comb begin
    wp_nxt     = wp_r;
    len_nxt    = len_r;
    rdy_nxt    = rdy_r;
    ovf_nxt    = ovf_r;
    trl_nxt    = trl_r;
    act_nxt    = act_r;
    idx_nxt    = idx_r;
    any_nxt    = any_r;
    store_en   = 1'b0;
    load       = 1'b0;
    o_has_nxt  = o_has_r;
    o_char_nxt = o_char_r;
    o_ovf_nxt  = o_ovf_r;
    o_trl_nxt  = o_trl_r;
    o_emp_nxt  = o_emp_r;
    o_avl_nxt  = o_avl_r;
    o_act_nxt  = o_act_r;
    o_last_nxt = o_last_r;

    unique case (op)
      OP_IDLE, OP_FETCH: begin
      end
      OP_BYTE: begin
        act_nxt = act_r + 16'd1;
        priority if (is_crlf) begin
          // skip line endings
        end else if (rdy_r) begin
          trl_nxt = 1'b1;
        end else if (in_rx_byte == CHAR_TERM) begin
          len_nxt = wp_r;
          rdy_nxt = 1'b1;
          wp_nxt  = '0;
        end else if (wp_r < PW'(MAX_PAYLOAD)) begin
          store_en = 1'b1;
          wp_nxt   = wp_r + PW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        wp_nxt  = '0;
        len_nxt = '0;
        rdy_nxt = 1'b0;
        ovf_nxt = 1'b0;
        trl_nxt = 1'b0;
      end
      OP_PEEK: begin
      end
      OP_READ_START: begin
        idx_nxt = '0;
        any_nxt = 1'b0;
      end
      OP_CHAR: begin
        idx_nxt = idx_r + AW'(1);
        any_nxt = 1'b1;
      end
      OP_READ_STATUS: begin
        wp_nxt  = '0;
        len_nxt = '0;
        rdy_nxt = 1'b0;
        ovf_nxt = 1'b0;
        trl_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // Result contents
    unique case (op)
      OP_BYTE, OP_CLEAR, OP_PEEK: begin
        load       = 1'b1;
        o_has_nxt  = 1'b0;
        o_char_nxt = 8'd0;
        o_ovf_nxt  = ovf_nxt;
        o_trl_nxt  = trl_nxt;
        o_emp_nxt  = 1'b0;
        o_avl_nxt  = rdy_nxt || ovf_nxt;
        o_act_nxt  = act_nxt;
        o_last_nxt = 1'b1;
      end
      OP_CHAR: begin
        load       = 1'b1;
        o_has_nxt  = 1'b1;
        o_char_nxt = rdata_r;
        o_ovf_nxt  = ovf_r;
        o_trl_nxt  = trl_r;
        o_emp_nxt  = 1'b0;
        o_avl_nxt  = rdy_r || ovf_r;
        o_act_nxt  = act_r;
        o_last_nxt = 1'b0;
      end
      OP_READ_STATUS: begin
        // flags as held before the clear
        load       = 1'b1;
        o_has_nxt  = 1'b0;
        o_char_nxt = 8'd0;
        o_ovf_nxt  = ovf_r;
        o_trl_nxt  = trl_r;
        o_emp_nxt  = !any_r && !ovf_r;
        o_avl_nxt  = rdy_r || ovf_r;
        o_act_nxt  = act_r;
        o_last_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[wp_r[AW-1:0]] <= in_rx_byte;
    end
    if (op == OP_FETCH) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      len_r       <= '0;
      rdy_r       <= 1'b0;
      ovf_r       <= 1'b0;
      trl_r       <= 1'b0;
      act_r       <= '0;
      idx_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      len_r       <= len_nxt;
      rdy_r       <= rdy_nxt;
      ovf_r       <= ovf_nxt;
      trl_r       <= trl_nxt;
      act_r       <= act_nxt;
      idx_r       <= idx_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_has_r  <= o_has_nxt;
    o_char_r <= o_char_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_trl_r  <= o_trl_nxt;
    o_emp_r  <= o_emp_nxt;
    o_avl_r  <= o_avl_nxt;
    o_act_r  <= o_act_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_has_char       = o_has_r;
  assign out_char_out       = o_char_r;
  assign out_overflow_flag  = o_ovf_r;
  assign out_trailing_flag  = o_trl_r;
  assign out_empty_flag     = o_emp_r;
  assign out_available      = o_avl_r;
  assign out_activity_count = o_act_r;
  assign out_last           = o_last_r;

endmodule

`default_nettype wire
